### src/urrb_pkg.sv
`timescale 1ns / 1ps

package urrb_pkg;

    localparam int DEFAULT_DEPTH = 64;

    localparam int BYTE_W = 8;
    localparam int FILL_W = 6;
    localparam int FUNC_W = 2;
    // wide enough for any index plus any 8-bit offset
    localparam int SUM_W  = 9;

    localparam logic [FUNC_W-1:0] FUNC_PUSH  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_POP   = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_PEEK  = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_FLUSH = 2'd3;

    localparam logic [BYTE_W-1:0] SEQ_FIRST  = 8'h40;
    localparam logic [BYTE_W-1:0] SEQ_SECOND = 8'h52;
    localparam logic [BYTE_W-1:0] CNT_MAX    = 8'hff;

    typedef struct packed {
        logic              is_read;
        logic [FILL_W-1:0] fill;
        logic [BYTE_W-1:0] overrun;
        logic              reset_req;
    } result_t;

endpackage

### src/urrb_store.sv
`timescale 1ns / 1ps

module urrb_store
    import urrb_pkg::*;
#(
    parameter int DEPTH  = DEFAULT_DEPTH,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [BYTE_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [BYTE_W-1:0] rd_data
);

    logic [BYTE_W-1:0] mem [DEPTH];
    logic [BYTE_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read data holds until the next read
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### src/uart_receive_ring_buffer.sv
`timescale 1ns / 1ps

// Receive FIFO for a serial link, holding up to DEPTH-1 bytes in a
// single-port-write, single-port-read byte memory. Each input transfer carries
// a command in s_tuser (push, pop, peek, flush) and returns exactly one result
// transfer with the read byte, the fill count and a saturating overrun count.
// A push while full drops the byte and bumps the overrun count; an 'R' received
// right after an '@' is not stored and raises reset_request instead. The block
// takes one item per clock unless a staged result is blocked, which drops
// s_tready. All pointer and counter updates happen in the accept cycle, the
// memory read of a pop or peek is registered at the accept edge along with the
// staged result, which moves to the output register when that register is free.
// One staged result plus the output register let a new item be taken while an
// earlier result still waits for m_tready.
module uart_receive_ring_buffer
    import urrb_pkg::*;
#(
    parameter int DEPTH = DEFAULT_DEPTH
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // rx_byte[7:0], peek_offset[15:8]
    input  logic [1:0]  s_tuser,   // func[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // data_byte[7:0], fill_count[13:8],
                                   // overrun_total[21:14], reset_request[22]
    output logic [0:0]  m_tuser    // data_valid[0]
);

    localparam int IDX_W = $clog2(DEPTH);

    logic [IDX_W-1:0]  wr_idx_reg, wr_idx_next;
    logic [IDX_W-1:0]  rd_idx_reg, rd_idx_next;
    logic [IDX_W-1:0]  count_reg, count_next;
    logic [BYTE_W-1:0] drop_reg, drop_next;
    logic [BYTE_W-1:0] prev_reg, prev_next;

    logic              pend_valid_reg, pend_valid_next;
    result_t           pend_reg, pend_next;

    logic              m_valid_reg, m_valid_next;
    logic              m_dv_reg, m_dv_next;
    logic [BYTE_W-1:0] m_byte_reg, m_byte_next;
    result_t           m_res_reg, m_res_next;

    logic              accept;
    logic              pend_move;
    logic [FUNC_W-1:0] func;
    logic [BYTE_W-1:0] rx_byte;
    logic [BYTE_W-1:0] peek_offset;
    logic              full;
    logic              empty;
    logic              peek_ok;
    logic [SUM_W-1:0]  peek_sum;
    logic [SUM_W-1:0]  peek_wrap;
    logic [SUM_W-1:0]  fill_wide;
    logic [SUM_W-1:0]  idx_sum;
    logic [SUM_W-1:0]  idx_wrap;

    logic              mem_wr_en;
    logic              mem_rd_en;
    logic [IDX_W-1:0]  mem_rd_addr;
    logic [BYTE_W-1:0] mem_rd_data;

    assign func        = s_tuser;
    assign rx_byte     = s_tdata[7:0];
    assign peek_offset = s_tdata[15:8];

    assign pend_move = pend_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready  = !pend_valid_reg || pend_move;
    assign accept    = s_tvalid && s_tready;

    assign full    = (count_reg == IDX_W'(DEPTH - 1));
    assign empty   = (count_reg == '0);
    assign peek_ok = (SUM_W'(peek_offset) < SUM_W'(count_reg));

    // offset stays below the fill count, so one subtract wraps it
    assign peek_sum  = SUM_W'(rd_idx_reg) + SUM_W'(peek_offset);
    assign peek_wrap = (peek_sum >= SUM_W'(DEPTH)) ? peek_sum - SUM_W'(DEPTH) : peek_sum;

    assign fill_wide = SUM_W'(count_next);

    always_comb begin
        wr_idx_next = wr_idx_reg;
        rd_idx_next = rd_idx_reg;
        count_next  = count_reg;
        drop_next   = drop_reg;
        prev_next   = prev_reg;
        mem_wr_en   = 1'b0;
        mem_rd_en   = 1'b0;
        mem_rd_addr = rd_idx_reg;
        pend_next   = pend_reg;

        if (accept) begin
            pend_next.is_read   = 1'b0;
            pend_next.reset_req = 1'b0;
            unique case (func)
                FUNC_PUSH: begin
                    if (rx_byte == SEQ_SECOND && prev_reg == SEQ_FIRST) begin
                        pend_next.reset_req = 1'b1;
                    end else begin
                        prev_next = rx_byte;
                        if (full) begin
                            if (drop_reg != CNT_MAX) begin
                                drop_next = drop_reg + 8'd1;
                            end
                        end else begin
                            mem_wr_en   = 1'b1;
                            wr_idx_next = (wr_idx_reg == IDX_W'(DEPTH - 1)) ? '0
                                        : wr_idx_reg + IDX_W'(1);
                            count_next  = count_reg + IDX_W'(1);
                        end
                    end
                end
                FUNC_POP: begin
                    if (!empty) begin
                        mem_rd_en         = 1'b1;
                        pend_next.is_read = 1'b1;
                        rd_idx_next = (rd_idx_reg == IDX_W'(DEPTH - 1)) ? '0
                                    : rd_idx_reg + IDX_W'(1);
                        count_next  = count_reg - IDX_W'(1);
                    end
                end
                FUNC_PEEK: begin
                    if (peek_ok) begin
                        mem_rd_en         = 1'b1;
                        mem_rd_addr       = peek_wrap[IDX_W-1:0];
                        pend_next.is_read = 1'b1;
                    end
                end
                FUNC_FLUSH: begin
                    wr_idx_next = '0;
                    rd_idx_next = '0;
                    count_next  = '0;
                    drop_next   = '0;
                end
                default: begin
                end
            endcase
            pend_next.fill    = fill_wide[FILL_W-1:0];
            pend_next.overrun = drop_next;
        end
    end

    always_comb begin
        pend_valid_next = pend_valid_reg;
        if (accept) begin
            pend_valid_next = 1'b1;
        end else if (pend_move) begin
            pend_valid_next = 1'b0;
        end

        m_valid_next = m_valid_reg;
        m_dv_next    = m_dv_reg;
        m_byte_next  = m_byte_reg;
        m_res_next   = m_res_reg;
        if (pend_move) begin
            m_valid_next = 1'b1;
            m_dv_next    = pend_reg.is_read;
            m_byte_next  = pend_reg.is_read ? mem_rd_data : '0;
            m_res_next   = pend_reg;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_idx_reg     <= '0;
            rd_idx_reg     <= '0;
            count_reg      <= '0;
            drop_reg       <= '0;
            prev_reg       <= '0;
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            wr_idx_reg     <= wr_idx_next;
            rd_idx_reg     <= rd_idx_next;
            count_reg      <= count_next;
            drop_reg       <= drop_next;
            prev_reg       <= prev_next;
            pend_valid_reg <= pend_valid_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        pend_reg   <= pend_next;
        m_dv_reg   <= m_dv_next;
        m_byte_reg <= m_byte_next;
        m_res_reg  <= m_res_next;
    end

    urrb_store #(
        .DEPTH  (DEPTH),
        .ADDR_W (IDX_W)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (mem_wr_en),
        .wr_addr (wr_idx_reg),
        .wr_data (rx_byte),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    assign m_tvalid   = m_valid_reg;
    assign m_tuser[0] = m_dv_reg;
    assign m_tdata    = {1'b0, m_res_reg.reset_req, m_res_reg.overrun,
                         m_res_reg.fill, m_byte_reg};

    // pointer bookkeeping: write index leads read index by the fill count
    assign idx_sum  = SUM_W'(rd_idx_reg) + SUM_W'(count_reg);
    assign idx_wrap = (idx_sum >= SUM_W'(DEPTH)) ? idx_sum - SUM_W'(DEPTH) : idx_sum;

    a_idx_consistent: assert property (@(posedge aclk) disable iff (!aresetn)
        idx_wrap[IDX_W-1:0] == wr_idx_reg)
        else $error("write index out of step with read index and count");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        SUM_W'(count_reg) <= SUM_W'(DEPTH - 1))
        else $error("fill count above capacity");

    a_no_read_on_request: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tuser[0] && m_tdata[22]))
        else $error("reset request together with a read byte");

    a_zero_when_invalid: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser[0]) |-> (m_tdata[7:0] == '0))
        else $error("data byte nonzero without data valid");

    a_pend_waits: assert property (@(posedge aclk) disable iff (!aresetn)
        (pend_valid_reg && m_valid_reg && !m_tready) |-> !s_tready)
        else $error("input taken while staged result is blocked");

endmodule
